@@ rtl/deque_with_linear_search_defines.svh @@
// Assertion helpers used by the deque checker.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef DEQUE_WITH_LINEAR_SEARCH_DEFINES_SVH
`define DEQUE_WITH_LINEAR_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

@@ rtl/deq_pkg.sv @@
`default_nettype none
package deq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// fixed field widths of the channels
	localparam int OP_W   = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 4;
	localparam int OCC_W  = 5;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	// per-cell control: load has priority over the shifts
	typedef struct packed {
		logic load;
		logic shr;
		logic shl;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/deq_if.sv @@
`default_nettype none
// Command channel: one deque operation per transaction.
interface deq_in_if;
	logic                    valid;
	logic                    ready;
	logic [2:0]              op;
	logic signed [31:0]      value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

// Response channel: one result per command.
interface deq_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [3:0] position;
	logic [4:0] occupancy;
	logic [1:0] status;

	modport source (output valid, output found, output position, output occupancy,
		output status, input ready);
	modport sink   (input valid, input found, input position, input occupancy,
		input status, output ready);
endinterface
`default_nettype wire

@@ rtl/deque_with_linear_search.sv @@
// Push and pop: result registered in the cycle after the command transaction; one per
// cycle while the response slot is free. Search: the ring of cells rotates DEPTH times
// past a single comparator at cell 0, and the next command follows the registered result.
// Reset (arst_n low) clears the entry count, the sequencer and the response valid;
// cell contents are left undefined and are only read after a push.
`default_nettype none
module deque_with_linear_search import deq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	deq_in_if.sink    cmd,
	deq_out_if.source rsp
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  step_q;
	logic [DATA_W-1:0] key_q;
	logic              hit_found_q;
	logic [IDX_W-1:0]  hit_pos_q;

	logic              rsp_valid_q;
	logic              found_q;
	logic [IDX_W-1:0]  pos_q;
	logic [CNT_W-1:0]  occ_q;
	status_t           status_q;

	logic              slot_free, accept, full, empty, last_step, hit;
	logic              search_adv, shr, shl, rsp_load, r_found;
	logic [IDX_W-1:0]  r_pos;
	status_t           r_status;
	logic [DEPTH-1:0]  load_mask;
	logic [DATA_W-1:0] cmd_data;

	logic [DATA_W-1:0] cell_data [DEPTH];
	cell_ctl_t         cell_ctl  [DEPTH];

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = cmd.valid && cmd.ready;
	assign cmd_data  = cmd.value[DATA_W-1:0];
	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign last_step = step_q == IDX_W'(DEPTH - 1);

	// compare the entry passing through cell 0 against the key
	assign hit = (CNT_W'(step_q) < count_q) && (cell_data[0] == key_q);

	// stall the rotation on its last step until the response slot is free
	assign search_adv = (state_q == S_SEARCH) && (!last_step || slot_free);

	// sequence the operation and steer the cells
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rsp_load  = 1'b0;
		r_found   = 1'b0;
		r_pos     = '0;
		r_status  = ST_DONE;
		shr       = 1'b0;
		shl       = 1'b0;
		load_mask = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_load = 1'b1;
					case (cmd.op)
						OP_PUSH_FRONT: begin
							if (full) begin
								r_status = ST_FULL;
							end else begin
								shr          = 1'b1;
								load_mask[0] = 1'b1;
								count_d      = count_q + 1'b1;
							end
						end
						OP_PUSH_BACK: begin
							if (full) begin
								r_status = ST_FULL;
							end else begin
								load_mask[count_q[IDX_W-1:0]] = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						OP_POP_FRONT: begin
							if (empty) begin
								r_status = ST_EMPTY;
							end else begin
								shl     = 1'b1;
								count_d = count_q - 1'b1;
							end
						end
						OP_POP_BACK: begin
							if (empty) begin
								r_status = ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						OP_SEARCH: begin
							rsp_load = 1'b0;
							state_d  = S_SEARCH;
						end
						default: ;
					endcase
				end
			end
			S_SEARCH: begin
				shl = search_adv;
				if (last_step && slot_free) begin
					rsp_load = 1'b1;
					r_found  = hit_found_q || hit;
					r_pos    = hit_found_q ? hit_pos_q : (hit ? step_q : '0);
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// chain of cells, closed into a ring so a full rotation restores order
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		localparam int LEFT  = (k + DEPTH - 1) % DEPTH;
		localparam int RIGHT = (k + 1) % DEPTH;

		assign cell_ctl[k] = '{load: load_mask[k], shr: shr, shl: shl};

		deq_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[k]),
			.load_d  (cmd_data),
			.left_d  (cell_data[LEFT]),
			.right_d (cell_data[RIGHT]),
			.data    (cell_data[k])
		);
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			hit_found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (accept) begin
				hit_found_q <= 1'b0;
			end else if (search_adv && hit) begin
				hit_found_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// advance the search step and capture the first match
	always_ff @(posedge clk) begin
		if (accept) begin
			step_q <= '0;
			key_q  <= cmd_data;
		end else if (search_adv) begin
			step_q <= step_q + 1'b1;
		end
		if (search_adv && hit && !hit_found_q) begin
			hit_pos_q <= step_q;
		end
		if (rsp_load) begin
			found_q  <= r_found;
			pos_q    <= r_pos;
			occ_q    <= count_d;
			status_q <= r_status;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.found     = found_q;
	assign rsp.position  = POS_W'(pos_q);
	assign rsp.occupancy = OCC_W'(occ_q);
	assign rsp.status    = status_q;

endmodule
`default_nettype wire

@@ rtl/deq_cell.sv @@
`default_nettype none
module deq_cell import deq_pkg::*; (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] load_d,
	input  logic [DATA_W-1:0] left_d,
	input  logic [DATA_W-1:0] right_d,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	// load a new entry, or take the neighbor's entry on a shift
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_d;
		end else if (ctl.shr) begin
			data_q <= left_d;
		end else if (ctl.shl) begin
			data_q <= right_d;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

@@ rtl/deq_checker.sv @@
`default_nettype none
`include "deque_with_linear_search_defines.svh"
module deq_checker import deq_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic              rsp_found,
	input wire logic [POS_W-1:0]  rsp_position,
	input wire logic [OCC_W-1:0]  rsp_occupancy,
	input wire logic [STAT_W-1:0] rsp_status
);

	// hold a pending response until it is taken
	`DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// a dropped push leaves the deque full
	`DEQ_ASSERT_NOW(a_full_occ, rsp_valid && rsp_status == ST_FULL,
		rsp_occupancy == OCC_W'(DEPTH))

	// an ignored pop leaves the deque empty
	`DEQ_ASSERT_NOW(a_empty_occ, rsp_valid && rsp_status == ST_EMPTY, rsp_occupancy == '0)

	// flagged operations never report a match
	`DEQ_ASSERT_NOW(a_flag_nomatch, rsp_valid && rsp_status != ST_DONE,
		!rsp_found && rsp_position == '0)

endmodule

bind deque_with_linear_search deq_checker u_deq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_found     (rsp.found),
	.rsp_position  (rsp.position),
	.rsp_occupancy (rsp.occupancy),
	.rsp_status    (rsp.status)
);
`default_nettype wire
